// File: rtl/core/rrtt_pkg.sv
`timescale 1ns / 1ps

package rrtt_pkg;

    // Default sizes of the table
    localparam int SLOTS_DEF   = 32;
    localparam int THREADS_DEF = 8;

    // Item field widths
    localparam int CMD_W      = 3;
    localparam int PID_W      = 8;
    localparam int SLOT_OUT_W = 5;
    localparam int THR_OUT_W  = 3;

    // Widths of values carried along the cell chain, sized for the largest
    // supported table (256 slots) and thread limit (64 threads)
    localparam int IDX_MAX_W = 8;
    localparam int CNT_MAX_W = 7;
    localparam int PTR_MAX_W = 6;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD        = 3'd0,
        CMD_ADD_THREAD = 3'd1,
        CMD_KILL       = 3'd2,
        CMD_QUERY      = 3'd3,
        CMD_TICK       = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    // Scheduling candidate picked up by a tick token
    typedef struct packed {
        logic                 valid;
        logic [IDX_MAX_W-1:0] idx;
        logic [PID_W-1:0]     pid;
        logic [PTR_MAX_W-1:0] ptr;
        logic [CNT_MAX_W-1:0] cnt;
    } cand_t;

    // Command token that walks from cell to cell
    typedef struct packed {
        logic                 valid;
        cmd_t                 cmd;
        logic [PID_W-1:0]     pid;
        logic [PID_W-1:0]     new_pid;
        logic [IDX_MAX_W-1:0] sp;
        logic                 done;
        logic                 hit;
        logic                 fail;
        logic [IDX_MAX_W-1:0] slot;
        cand_t                aft;
        cand_t                lead;
    } token_t;

    // Thread pointer write-back broadcast after a tick
    typedef struct packed {
        logic                 valid;
        logic [IDX_MAX_W-1:0] idx;
        logic [PTR_MAX_W-1:0] ptr;
    } wb_t;

endpackage

// File: rtl/core/rrtt_req_if.sv
`timescale 1ns / 1ps

interface rrtt_req_if;
    logic                       valid;
    logic                       ready;
    logic [rrtt_pkg::CMD_W-1:0] cmd;
    logic [rrtt_pkg::PID_W-1:0] pid;

    modport source (output valid, output cmd, output pid, input ready);
    modport sink   (input valid, input cmd, input pid, output ready);
endinterface

// File: rtl/core/rrtt_rsp_if.sv
`timescale 1ns / 1ps

interface rrtt_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            status;
    logic [rrtt_pkg::PID_W-1:0]      result_pid;
    logic [rrtt_pkg::SLOT_OUT_W-1:0] slot;
    logic [rrtt_pkg::THR_OUT_W-1:0]  thread_index;
    logic                            running;

    modport source (output valid, output status, output result_pid, output slot,
                    output thread_index, output running, input ready);
    modport sink   (input valid, input status, input result_pid, input slot,
                    input thread_index, input running, output ready);
endinterface

// File: rtl/core/round_robin_task_table.sv
`timescale 1ns / 1ps

// Round-robin task table.
// req carries one command item (cmd, pid): add process, add thread, kill,
// query, or scheduler tick. rsp returns exactly one result item per command
// (status, result_pid, slot, thread_index, running). Both channels move an
// item when valid and ready are high at a rising edge of clk.
// Each table slot lives in one cell of a chain; an accepted command travels
// as a token one cell per cycle, and each cell updates its slot as the token
// passes. A tick picks its slot at the end of the chain and broadcasts the
// new thread pointer back to that slot.
// One command is in flight at a time: a new item is not accepted until
// the token of the last one has walked the whole cell chain and its result
// has been loaded into the output register.
// A result waits in the output register while the next item is accepted and
// walks the chain; a stalled receiver only holds the finished token.
// rst_n (asynchronous, active low) empties the table and zeroes the slot
// pointer and the pid counter; no clearing pass is needed.
module round_robin_task_table #(
    parameter int SLOTS               = rrtt_pkg::SLOTS_DEF,
    parameter int THREADS_PER_PROCESS = rrtt_pkg::THREADS_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    rrtt_req_if.sink   req,
    rrtt_rsp_if.source rsp
);

    localparam int SLOT_W = $clog2(SLOTS);

    rrtt_pkg::state_t           state_reg, state_next;
    rrtt_pkg::token_t           launch_reg, launch_next;
    rrtt_pkg::token_t           fin_reg;
    rrtt_pkg::token_t           link [SLOTS+1];
    rrtt_pkg::wb_t              wb;
    rrtt_pkg::cand_t            sel;

    logic [rrtt_pkg::PID_W-1:0] next_pid_reg, next_pid_next;
    logic [SLOT_W-1:0]          sp_reg, sp_next;
    logic [rrtt_pkg::PID_W-1:0] cur_pid_reg, cur_pid_next;
    logic                       cur_valid_reg, cur_valid_next;

    logic                       rsp_valid_reg, rsp_valid_next;
    logic                       status_reg, status_next;
    logic [rrtt_pkg::PID_W-1:0] result_pid_reg, result_pid_next;
    logic [rrtt_pkg::SLOT_OUT_W-1:0] slot_reg, slot_next;
    logic [rrtt_pkg::THR_OUT_W-1:0]  thread_reg, thread_next;
    logic                       running_reg, running_next;

    logic                       req_fire;
    logic                       rsp_load;
    logic                       in_ready;
    logic [rrtt_pkg::CNT_MAX_W-1:0] t_inc;
    logic [rrtt_pkg::CNT_MAX_W-1:0] t_new;
    logic [SLOTS:0]             tok_valid;

    // Handshakes
    assign req_fire  = req.valid && in_ready;
    assign req.ready = in_ready;

    // Feed the chain
    assign link[0] = launch_reg;

    for (genvar g = 0; g < SLOTS; g++)
    begin : g_cell
        rrtt_cell #(
            .CELL_IDX (g),
            .THREADS  (THREADS_PER_PROCESS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (link[g]),
            .wb      (wb),
            .tok_out (link[g+1])
        );
    end

    // Collect token presence along the chain
    always_comb
    begin
        for (int i = 0; i <= SLOTS; i++)
        begin
            tok_valid[i] = link[i].valid;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rrtt_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = rrtt_pkg::ST_RUN;
                end
            end
            rrtt_pkg::ST_RUN:
            begin
                if (link[SLOTS].valid)
                begin
                    state_next = rrtt_pkg::ST_DONE;
                end
            end
            rrtt_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    state_next = rrtt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rrtt_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        rsp_load = 1'b0;
        unique case (state_reg)
            rrtt_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            rrtt_pkg::ST_RUN:
            begin
                in_ready = 1'b0;
            end
            rrtt_pkg::ST_DONE:
            begin
                rsp_load = !rsp_valid_reg || rsp.ready;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Launch a token on acceptance; advance the pid counter on every add
    always_comb
    begin
        launch_next   = '0;
        next_pid_next = next_pid_reg;
        if (req_fire)
        begin
            launch_next.valid   = 1'b1;
            launch_next.cmd     = rrtt_pkg::cmd_t'(req.cmd);
            launch_next.pid     = req.pid;
            launch_next.new_pid = next_pid_reg;
            launch_next.sp      = rrtt_pkg::IDX_MAX_W'(sp_reg);
            if (req.cmd == rrtt_pkg::CMD_ADD)
            begin
                next_pid_next = next_pid_reg + rrtt_pkg::PID_W'(1);
            end
        end
    end

    // Pick the tick winner: first used slot past the pointer, else the lowest
    assign sel   = fin_reg.aft.valid ? fin_reg.aft : fin_reg.lead;
    assign t_inc = rrtt_pkg::CNT_MAX_W'(sel.ptr) + rrtt_pkg::CNT_MAX_W'(1);
    assign t_new = ((t_inc >= sel.cnt)
                    || (t_inc >= rrtt_pkg::CNT_MAX_W'(THREADS_PER_PROCESS)))
                   ? '0 : t_inc;

    // Decode the finished token into a result and scheduler updates
    always_comb
    begin
        status_next     = status_reg;
        result_pid_next = result_pid_reg;
        slot_next       = slot_reg;
        thread_next     = thread_reg;
        running_next    = running_reg;
        sp_next         = sp_reg;
        cur_pid_next    = cur_pid_reg;
        cur_valid_next  = cur_valid_reg;
        wb              = '0;
        if (rsp_load)
        begin
            status_next     = 1'b1;
            result_pid_next = '0;
            slot_next       = '0;
            thread_next     = '0;
            running_next    = 1'b0;
            unique case (fin_reg.cmd)
                rrtt_pkg::CMD_ADD:
                begin
                    status_next     = !fin_reg.done;
                    result_pid_next = fin_reg.new_pid;
                    slot_next       = fin_reg.done
                                      ? fin_reg.slot[rrtt_pkg::SLOT_OUT_W-1:0] : '0;
                end
                rrtt_pkg::CMD_ADD_THREAD:
                begin
                    status_next = !fin_reg.done || fin_reg.fail;
                end
                rrtt_pkg::CMD_KILL:
                begin
                    status_next = !fin_reg.hit;
                    if (fin_reg.hit && cur_valid_reg && (cur_pid_reg == fin_reg.pid))
                    begin
                        cur_valid_next = 1'b0;
                    end
                end
                rrtt_pkg::CMD_QUERY:
                begin
                    status_next  = 1'b0;
                    running_next = fin_reg.hit;
                end
                rrtt_pkg::CMD_TICK:
                begin
                    if (sel.valid)
                    begin
                        status_next     = 1'b0;
                        result_pid_next = sel.pid;
                        slot_next       = sel.idx[rrtt_pkg::SLOT_OUT_W-1:0];
                        thread_next     = t_new[rrtt_pkg::THR_OUT_W-1:0];
                        sp_next         = sel.idx[SLOT_W-1:0];
                        cur_pid_next    = sel.pid;
                        cur_valid_next  = 1'b1;
                        wb.valid        = 1'b1;
                        wb.idx          = sel.idx;
                        wb.ptr          = t_new[rrtt_pkg::PTR_MAX_W-1:0];
                    end
                    else
                    begin
                        cur_valid_next = 1'b0;
                    end
                end
                default:
                begin
                    status_next = 1'b1;
                end
            endcase
        end
    end

    // Output valid: set on load, drop once taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rrtt_pkg::ST_IDLE;
            launch_reg    <= '0;
            next_pid_reg  <= '0;
            sp_reg        <= '0;
            cur_pid_reg   <= '0;
            cur_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            next_pid_reg  <= next_pid_next;
            sp_reg        <= sp_next;
            cur_pid_reg   <= cur_pid_next;
            cur_valid_reg <= cur_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if ((state_reg == rrtt_pkg::ST_RUN) && link[SLOTS].valid)
        begin
            fin_reg <= link[SLOTS];
        end
        status_reg     <= status_next;
        result_pid_reg <= result_pid_next;
        slot_reg       <= slot_next;
        thread_reg     <= thread_next;
        running_reg    <= running_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.status       = status_reg;
    assign rsp.result_pid   = result_pid_reg;
    assign rsp.slot         = slot_reg;
    assign rsp.thread_index = thread_reg;
    assign rsp.running      = running_reg;

    // Only one command token may be on the chain
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(tok_valid) <= 1)
        else $error("more than one token on the cell chain");

    // The token leaves the chain only while the controller waits for it
    a_exit_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        link[SLOTS].valid |-> (state_reg == rrtt_pkg::ST_RUN))
        else $error("token left the chain outside the run state");

    // A successful tick moves the slot pointer and marks a current process
    a_tick_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_load && (fin_reg.cmd == rrtt_pkg::CMD_TICK) && sel.valid)
        |=> (cur_valid_reg && (sp_reg == $past(sel.idx[SLOT_W-1:0]))))
        else $error("tick did not commit the scheduled slot");

    // Every accepted add consumes one pid
    a_add_pid: assert property (@(posedge clk) disable iff (!rst_n)
        (req_fire && (req.cmd == rrtt_pkg::CMD_ADD))
        |=> (next_pid_reg == $past(next_pid_reg) + rrtt_pkg::PID_W'(1)))
        else $error("add did not advance the pid counter");

endmodule

// File: rtl/core/rrtt_cell.sv
`timescale 1ns / 1ps

module rrtt_cell #(
    parameter int CELL_IDX = 0,
    parameter int THREADS  = rrtt_pkg::THREADS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  rrtt_pkg::token_t tok_in,
    input  rrtt_pkg::wb_t    wb,
    output rrtt_pkg::token_t tok_out
);

    localparam int CNT_W = $clog2(THREADS + 1);
    localparam int PTR_W = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam logic [rrtt_pkg::IDX_MAX_W-1:0] MY_IDX = rrtt_pkg::IDX_MAX_W'(CELL_IDX);

    logic                       used_reg, used_next;
    logic [rrtt_pkg::PID_W-1:0] pid_reg, pid_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [PTR_W-1:0]           ptr_reg, ptr_next;
    rrtt_pkg::token_t           tok_reg, tok_next;

    logic                       hit_me;
    logic [CNT_W:0]             cnt_inc;
    rrtt_pkg::cand_t            mine;

    // Local view of this slot
    assign hit_me  = used_reg && (pid_reg == tok_in.pid);
    assign cnt_inc = (CNT_W + 1)'(cnt_reg) + (CNT_W + 1)'(1);

    always_comb
    begin
        mine.valid = 1'b1;
        mine.idx   = MY_IDX;
        mine.pid   = pid_reg;
        mine.ptr   = rrtt_pkg::PTR_MAX_W'(ptr_reg);
        mine.cnt   = rrtt_pkg::CNT_MAX_W'(cnt_reg);
    end

    // Act on the passing token and hand it on
    always_comb
    begin
        used_next = used_reg;
        pid_next  = pid_reg;
        cnt_next  = cnt_reg;
        ptr_next  = ptr_reg;
        tok_next  = tok_in;
        if (tok_in.valid)
        begin
            unique case (tok_in.cmd)
                rrtt_pkg::CMD_ADD:
                begin
                    if (!used_reg && !tok_in.done)
                    begin
                        used_next     = 1'b1;
                        pid_next      = tok_in.new_pid;
                        cnt_next      = CNT_W'(1);
                        ptr_next      = '0;
                        tok_next.done = 1'b1;
                        tok_next.slot = MY_IDX;
                    end
                end
                rrtt_pkg::CMD_ADD_THREAD:
                begin
                    if (hit_me && !tok_in.done)
                    begin
                        tok_next.done = 1'b1;
                        if (cnt_inc > (CNT_W + 1)'(THREADS))
                        begin
                            tok_next.fail = 1'b1;
                        end
                        else
                        begin
                            cnt_next = cnt_inc[CNT_W-1:0];
                        end
                    end
                end
                rrtt_pkg::CMD_KILL:
                begin
                    if (hit_me)
                    begin
                        used_next    = 1'b0;
                        tok_next.hit = 1'b1;
                    end
                end
                rrtt_pkg::CMD_QUERY:
                begin
                    if (hit_me)
                    begin
                        tok_next.hit = 1'b1;
                    end
                end
                rrtt_pkg::CMD_TICK:
                begin
                    if (used_reg)
                    begin
                        if (!tok_in.lead.valid)
                        begin
                            tok_next.lead = mine;
                        end
                        if (!tok_in.aft.valid && (MY_IDX > tok_in.sp))
                        begin
                            tok_next.aft = mine;
                        end
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
        // Apply the thread pointer chosen by a finished tick
        if (wb.valid && (wb.idx == MY_IDX))
        begin
            ptr_next = wb.ptr[PTR_W-1:0];
        end
    end

    // Hold the slot occupancy and the token stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end
        else
        begin
            used_reg <= used_next;
            tok_reg  <= tok_next;
        end
    end

    // Hold the slot contents
    always_ff @(posedge clk)
    begin
        pid_reg <= pid_next;
        cnt_reg <= cnt_next;
        ptr_reg <= ptr_next;
    end

    assign tok_out = tok_reg;

endmodule

// File: test/round_robin_task_table_test.sv
`timescale 1ns / 1ps

module round_robin_task_table_test;

    localparam int SLOTS       = rrtt_pkg::SLOTS_DEF;
    localparam int THREADS     = rrtt_pkg::THREADS_DEF;
    localparam int LATENCY     = SLOTS + 2;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASE_ITEMS = 330;
    localparam int MAX_PRINTED = 40;

    localparam logic [rrtt_pkg::CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
    localparam logic [rrtt_pkg::CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
    localparam logic                       STATUS_OK     = 1'b0;
    localparam logic                       STATUS_FAIL   = 1'b1;

    typedef struct packed {
        logic                            status;
        logic [rrtt_pkg::PID_W-1:0]      pid;
        logic [rrtt_pkg::SLOT_OUT_W-1:0] slot;
        logic [rrtt_pkg::THR_OUT_W-1:0]  thread;
        logic                            running;
    } task_result_t;

    // Mirror of the task table; predicts one result per accepted command
    class task_table_scoreboard;
        bit                         used[SLOTS];
        logic [rrtt_pkg::PID_W-1:0] slot_pid[SLOTS];
        int unsigned                thread_count[SLOTS];
        int unsigned                thread_ptr[SLOTS];
        int unsigned                rr_slot;
        logic [rrtt_pkg::PID_W-1:0] pid_counter;
        logic [rrtt_pkg::PID_W-1:0] sched_pid;
        bit                         sched_valid;
        task_result_t               pending[$];
        int unsigned                mismatches;
        int unsigned                commands;
        int unsigned                results;
        int unsigned                full_rejects;
        int unsigned                limit_rejects;
        int unsigned                empty_ticks;
        int unsigned                multi_kills;

        function new();
            foreach (used[i])
            begin
                used[i]         = 1'b0;
                slot_pid[i]     = '0;
                thread_count[i] = 0;
                thread_ptr[i]   = 0;
            end
            rr_slot       = 0;
            pid_counter   = '0;
            sched_pid     = '0;
            sched_valid   = 1'b0;
            mismatches    = 0;
            commands      = 0;
            results       = 0;
            full_rejects  = 0;
            limit_rejects = 0;
            empty_ticks   = 0;
            multi_kills   = 0;
        endfunction

        function int unsigned used_count();
            int unsigned n;
            n = 0;
            foreach (used[i])
                if (used[i])
                    n++;
            return n;
        endfunction

        // Apply one accepted command to the mirror and queue its result
        function void note_command(logic [rrtt_pkg::CMD_W-1:0] code,
                                   logic [rrtt_pkg::PID_W-1:0] id);
            task_result_t r;
            int unsigned  s;
            int unsigned  t;
            int unsigned  hits;
            bit           found;
            r     = '0;
            found = 1'b0;
            hits  = 0;
            commands++;
            case (code)
                rrtt_pkg::CMD_ADD:
                begin
                    r.pid    = pid_counter;
                    r.status = STATUS_FAIL;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!found && !used[i])
                        begin
                            found           = 1'b1;
                            used[i]         = 1'b1;
                            slot_pid[i]     = pid_counter;
                            thread_count[i] = 1;
                            thread_ptr[i]   = 0;
                            r.status        = STATUS_OK;
                            r.slot          = rrtt_pkg::SLOT_OUT_W'(i);
                        end
                    end
                    if (!found)
                        full_rejects++;
                    // the counter moves on even when the table is full
                    pid_counter = pid_counter + rrtt_pkg::PID_W'(1);
                end
                rrtt_pkg::CMD_ADD_THREAD:
                begin
                    r.status = STATUS_FAIL;
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (!found && used[i] && slot_pid[i] == id)
                        begin
                            found = 1'b1;
                            if (thread_count[i] + 1 > THREADS)
                                limit_rejects++;
                            else
                            begin
                                thread_count[i]++;
                                r.status = STATUS_OK;
                            end
                        end
                    end
                end
                rrtt_pkg::CMD_KILL:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (used[i] && slot_pid[i] == id)
                        begin
                            used[i] = 1'b0;
                            hits++;
                        end
                    end
                    if (hits > 0 && sched_valid && sched_pid == id)
                        sched_valid = 1'b0;
                    if (hits > 1)
                        multi_kills++;
                    r.status = (hits > 0) ? STATUS_OK : STATUS_FAIL;
                end
                rrtt_pkg::CMD_QUERY:
                begin
                    r.status = STATUS_OK;
                    for (int i = 0; i < SLOTS; i++)
                        if (used[i] && slot_pid[i] == id)
                            r.running = 1'b1;
                end
                rrtt_pkg::CMD_TICK:
                begin
                    r.status = STATUS_FAIL;
                    // scan from the slot after the pointer round to the pointer itself
                    for (int n = 1; n <= SLOTS; n++)
                    begin
                        s = (rr_slot + n) % SLOTS;
                        if (!found && used[s])
                        begin
                            found = 1'b1;
                            t     = thread_ptr[s] + 1;
                            if (t >= thread_count[s] || t >= THREADS)
                                t = 0;
                            thread_ptr[s] = t;
                            rr_slot       = s;
                            sched_pid     = slot_pid[s];
                            sched_valid   = 1'b1;
                            r.status      = STATUS_OK;
                            r.pid         = slot_pid[s];
                            r.slot        = rrtt_pkg::SLOT_OUT_W'(s);
                            r.thread      = rrtt_pkg::THR_OUT_W'(t);
                        end
                    end
                    if (!found)
                    begin
                        sched_valid = 1'b0;
                        empty_ticks++;
                    end
                end
                default:
                    r.status = STATUS_FAIL;
            endcase
            pending.push_back(r);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] mismatch on result %0d: %s", $time, results, msg);
        endtask

        // Compare one accepted result with the oldest prediction
        task check_result(task_result_t got);
            task_result_t want;
            results++;
            if (pending.size() == 0)
                report_mismatch("result with no command outstanding");
            else
            begin
                want = pending.pop_front();
                if (got.status !== want.status)
                    report_mismatch($sformatf("status %b, expected %b",
                                              got.status, want.status));
                if (got.pid !== want.pid)
                    report_mismatch($sformatf("result_pid %0d, expected %0d",
                                              got.pid, want.pid));
                if (got.slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d",
                                              got.slot, want.slot));
                if (got.thread !== want.thread)
                    report_mismatch($sformatf("thread_index %0d, expected %0d",
                                              got.thread, want.thread));
                if (got.running !== want.running)
                    report_mismatch($sformatf("running %b, expected %b",
                                              got.running, want.running));
            end
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        rx_hold;
    int          tx_idle_pct;
    int          rx_idle_pct;
    int unsigned cycle_count;

    task_table_scoreboard sb = new();

    rrtt_req_if req();
    rrtt_rsp_if rsp();

    round_robin_task_table #(
        .SLOTS               (SLOTS),
        .THREADS_PER_PROCESS (THREADS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Abort a run that hangs
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending.size());
            $display("round_robin_task_table_test NOT OK");
            $finish;
        end
    end

    // Result side: check accepted items, then pick the next ready
    initial
    begin
        rsp.ready = 1'b0;
        rx_hold   = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result('{rsp.status, rsp.result_pid, rsp.slot,
                              rsp.thread_index, rsp.running});
        rsp.ready <= rst_n && !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end

    // Hold the result side off long enough for the block to stall its input
    task automatic hold_receiver();
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    endtask

    // Offer one command item and wait until it is taken
    task automatic send_item(input logic [rrtt_pkg::CMD_W-1:0] code,
                             input logic [rrtt_pkg::PID_W-1:0] id);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.cmd   <= code;
        req.pid   <= id;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_command(code, id);
    endtask

    // Mostly pids that live in the table, sometimes any pid
    function automatic logic [rrtt_pkg::PID_W-1:0] pick_pid();
        int unsigned k;
        int unsigned n;
        logic [rrtt_pkg::PID_W-1:0] id;
        n  = sb.used_count();
        id = rrtt_pkg::PID_W'($urandom_range(255));
        if (n != 0 && $urandom_range(99) < 80)
        begin
            k = $urandom_range(n - 1);
            foreach (sb.used[i])
            begin
                if (sb.used[i])
                begin
                    if (k == 0)
                        id = sb.slot_pid[i];
                    k--;
                end
            end
        end
        return id;
    endfunction

    task automatic random_item();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 25)
            send_item(rrtt_pkg::CMD_ADD, rrtt_pkg::PID_W'($urandom_range(255)));
        else if (r < 45)
            send_item(rrtt_pkg::CMD_ADD_THREAD, pick_pid());
        else if (r < 57)
            send_item(rrtt_pkg::CMD_KILL, pick_pid());
        else if (r < 70)
            send_item(rrtt_pkg::CMD_QUERY, pick_pid());
        else if (r < 95)
            send_item(rrtt_pkg::CMD_TICK, rrtt_pkg::PID_W'($urandom_range(255)));
        else
            send_item(rrtt_pkg::CMD_W'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO)),
                      rrtt_pkg::PID_W'($urandom_range(255)));
    endtask

    // Kill every process so the phase starts from an empty table
    task automatic drain_table();
        int i;
        while (sb.used_count() != 0)
        begin
            i = 0;
            while (!sb.used[i])
                i++;
            send_item(rrtt_pkg::CMD_KILL, sb.slot_pid[i]);
        end
    endtask

    task automatic run_phase(input int tx_pct, input int rx_pct, input bit with_hold);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        drain_table();
        if (with_hold)
            fork
                hold_receiver();
            join_none
        repeat (PHASE_ITEMS) random_item();
    endtask

    // Stimulus
    initial
    begin
        req.valid   <= 1'b0;
        req.cmd     <= rrtt_pkg::CMD_ADD;
        req.pid     <= '0;
        rst_n       <= 1'b0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty table: kill and thread add fail, query finds nothing running, tick reports nothing to run
        send_item(rrtt_pkg::CMD_TICK, 8'd0);
        send_item(rrtt_pkg::CMD_QUERY, 8'd0);
        send_item(rrtt_pkg::CMD_KILL, 8'd0);
        send_item(rrtt_pkg::CMD_ADD_THREAD, 8'd0);
        send_item(CMD_UNUSED_LO, 8'd255);
        send_item(CMD_UNUSED_HI, 8'd170);
        // lone process is picked again on every tick
        send_item(rrtt_pkg::CMD_ADD, 8'd85);
        send_item(rrtt_pkg::CMD_TICK, 8'd0);
        // grow to the thread limit, then one more is refused
        repeat (THREADS - 1) send_item(rrtt_pkg::CMD_ADD_THREAD, 8'd0);
        send_item(rrtt_pkg::CMD_ADD_THREAD, 8'd0);
        send_item(rrtt_pkg::CMD_TICK, 8'd0);
        send_item(rrtt_pkg::CMD_TICK, 8'd255);
        send_item(rrtt_pkg::CMD_QUERY, 8'd0);
        send_item(rrtt_pkg::CMD_QUERY, 8'd255);
        // killing the scheduled process empties the table again
        send_item(rrtt_pkg::CMD_KILL, 8'd0);
        send_item(rrtt_pkg::CMD_TICK, 8'd0);

        run_phase(38, 68, 1'b0);
        run_phase(68, 38, 1'b0);
        run_phase(0, 0, 1'b1);
        req.valid <= 1'b0;

        // drain outstanding results, then watch for stray ones
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 1) @(posedge clk);

        $display("ran %0d commands, %0d results; %0d adds hit a full table",
                 sb.commands, sb.results, sb.full_rejects);
        $display("%0d thread adds refused, %0d empty ticks, %0d repeated-pid kills",
                 sb.limit_rejects, sb.empty_ticks, sb.multi_kills);
        if (sb.mismatches == 0)
            $display("round_robin_task_table_test OK");
        else
            $display("round_robin_task_table_test NOT OK");
        $finish;
    end

endmodule
